// ===== design/olir_pkg.sv =====
// Package: shared types and codes for the ordered list with positional insert and remove.
`default_nettype none
package olir_pkg;

    // Widths of the word fields, fixed by the channel format.
    localparam int unsigned OPCODE_W   = 3;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POSITION_W = 7;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned LENGTH_W   = 7;

    // Operation codes carried by an input word.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_HEAD    = 3'd0,
        OP_ADD_TAIL    = 3'd1,
        OP_REMOVE_HEAD = 3'd2,
        OP_REMOVE_TAIL = 3'd3,
        OP_CLEAR       = 3'd4,
        OP_INSERT_AT   = 3'd5,
        OP_REMOVE_AT   = 3'd6
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Command broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cell_cmd_t;

endpackage
`default_nettype wire

// ===== design/olir_in_if.sv =====
// Interface: input channel carrying one operation word.
`default_nettype none
interface olir_in_if
    import olir_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [OPCODE_W-1:0]         opcode;
    logic signed [VALUE_W-1:0]   value;
    logic [POSITION_W-1:0]       position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface
`default_nettype wire

// ===== design/olir_out_if.sv =====
// Interface: output channel carrying one result word.
`default_nettype none
interface olir_out_if
    import olir_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   removed_value;
    logic [LENGTH_W-1:0]         length;

    modport source (output valid, status, removed_value, length, input ready);
    modport sink   (input valid, status, removed_value, length, output ready);
endinterface
`default_nettype wire

// ===== design/olir_cell.sv =====
// Module: one storage cell of the list row, shifting with its neighbors.
`default_nettype none
module olir_cell
    import olir_pkg::*;
#(
    parameter int unsigned CW    = 7,
    parameter int unsigned INDEX = 0
) (
    input  wire logic                      clk,
    input  wire cell_cmd_t                 cmd,
    input  wire logic [CW-1:0]             pos,
    input  wire logic signed [VALUE_W-1:0] new_value,
    input  wire logic signed [VALUE_W-1:0] left_value,
    input  wire logic signed [VALUE_W-1:0] right_value,
    output logic signed [VALUE_W-1:0]      value,
    output logic signed [VALUE_W-1:0]      hit_value
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // Insert opens a gap at pos; remove closes the gap at pos.
    always_comb
    begin
        value_next = value_reg;
        case (cmd)
            CMD_INSERT:
            begin
                if (MY_INDEX > pos)
                begin
                    value_next = left_value;
                end
                else if (MY_INDEX == pos)
                begin
                    value_next = new_value;
                end
            end
            CMD_REMOVE:
            begin
                if (MY_INDEX >= pos)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Offer the stored value when this cell is the one addressed.
    assign hit_value = (MY_INDEX == pos) ? value_reg : '0;
    assign value     = value_reg;

endmodule
`default_nettype wire

// ===== design/ordered_list_insert_remove_top.sv =====
// Top level: ordered list of signed values built from a row of shifting cells.
//
//   channel  | dir | fields
//   ---------+-----+----------------------------------------
//   in_ch    | in  | opcode[2:0], value[31:0], position[6:0]
//   out_ch   | out | status[1:0], removed_value[31:0], length[6:0]
//
// One word is taken per cycle unless out_ch stalls: the whole row of cells shifts
// in the cycle the word is accepted, and the result is held in an output register.
// A new word is accepted while the held result is taken in the same cycle.
// Reset empties the list; cell contents are not cleared.
// A stall on out_ch holds the result and stops intake until it is taken.
`default_nettype none
module ordered_list_insert_remove_top
    import olir_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    olir_in_if.sink   in_ch,
    olir_out_if.source out_ch
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CW > POSITION_W) ? CW : POSITION_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic [LENGTH_W-1:0]       length_reg;

    logic                      accept;
    logic [AW-1:0]             cnt_ext;
    logic [AW-1:0]             pos_ext;
    logic [AW-1:0]             op_pos;
    logic [AW-1:0]             length_ext;
    logic                      want_insert;
    logic                      want_remove;
    logic                      do_insert;
    logic                      do_remove;
    status_t                   status;
    cell_cmd_t                 cmd;
    logic [CW-1:0]             cell_pos;
    logic signed [VALUE_W-1:0] taken;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic signed [VALUE_W-1:0] cell_hit   [CAPACITY];

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign cnt_ext     = AW'(count_reg);
    assign pos_ext     = AW'(in_ch.position);

    // Decode the operation and its target position.
    always_comb
    begin
        want_insert = 1'b0;
        want_remove = 1'b0;
        op_pos      = '0;
        case (in_ch.opcode)
            OP_ADD_HEAD:
            begin
                want_insert = 1'b1;
            end
            OP_ADD_TAIL:
            begin
                want_insert = 1'b1;
                op_pos      = cnt_ext;
            end
            OP_REMOVE_HEAD:
            begin
                want_remove = 1'b1;
            end
            OP_REMOVE_TAIL:
            begin
                want_remove = 1'b1;
                op_pos      = cnt_ext - AW'(1);
            end
            OP_INSERT_AT:
            begin
                want_insert = 1'b1;
                op_pos      = pos_ext;
            end
            OP_REMOVE_AT:
            begin
                want_remove = 1'b1;
                op_pos      = pos_ext;
            end
            default:
            begin
                want_insert = 1'b0;
            end
        endcase
    end

    // Range and capacity checks; the range check wins over the full check.
    always_comb
    begin
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        status     = ST_IGNORED;
        count_next = count_reg;
        if (want_insert)
        begin
            if (op_pos > cnt_ext)
            begin
                status = ST_IGNORED;
            end
            else if (count_reg == FULL_COUNT)
            begin
                status = ST_FULL;
            end
            else
            begin
                status     = ST_DONE;
                do_insert  = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
        else if (want_remove)
        begin
            if (op_pos >= cnt_ext)
            begin
                status = ST_IGNORED;
            end
            else
            begin
                status     = ST_DONE;
                do_remove  = 1'b1;
                count_next = count_reg - CW'(1);
            end
        end
        else if (in_ch.opcode == OP_CLEAR)
        begin
            status     = ST_DONE;
            count_next = '0;
        end
    end

    // Command broadcast to the cell row; the position is below CAPACITY when used.
    assign cell_pos = op_pos[CW-1:0];
    always_comb
    begin
        cmd = CMD_HOLD;
        if (accept && do_insert)
        begin
            cmd = CMD_INSERT;
        end
        else if (accept && do_remove)
        begin
            cmd = CMD_REMOVE;
        end
    end

    // Row of cells; the last cell refills itself on a remove.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = in_ch.value;
        end
        else
        begin : g_mid_left
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_mid_right
            assign right_value = cell_value[i+1];
        end

        olir_cell #(
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .pos         (cell_pos),
            .new_value   (in_ch.value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .hit_value   (cell_hit[i])
        );
    end

    // Gather the addressed cell's value; at most one cell is nonzero.
    always_comb
    begin
        taken = '0;
        for (int unsigned k = 0; k < CAPACITY; k++)
        begin
            taken = taken | cell_hit[k];
        end
    end

    assign length_ext     = AW'(count_next);
    assign out_valid_next = accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status;
            removed_reg <= do_remove ? taken : '0;
            length_reg  <= length_ext[LENGTH_W-1:0];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.removed_value = removed_reg;
    assign out_ch.length        = length_reg;

endmodule
`default_nettype wire
